// ===== design/ecd_pkg.sv =====
// Package for the seconds-to-calendar converter: field widths, constants,
// reciprocal multipliers, month tables and the structs passed between stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ecd_pkg;

  localparam int unsigned EPOCH_W   = 32;
  localparam int unsigned YEAR_W    = 12;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MINUTE_W  = 6;
  localparam int unsigned SECOND_W  = 6;
  localparam int unsigned WEEKDAY_W = 3;

  localparam int unsigned DAYNUM_W  = 16;  // whole days since the epoch
  localparam int unsigned SOD_W     = 17;  // second of day
  localparam int unsigned ABSDAY_W  = 20;  // days since 0001-01-01
  localparam int unsigned DOY_W     = 9;   // day of year
  localparam int unsigned CENT_W    = 6;   // year / 100

  // Register stages from input to output register
  localparam int unsigned STAGES = 11;

  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int unsigned SEC_PER_DAY  = 86400;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned YEAR_BEFORE_EPOCH = 1969;
  localparam int unsigned DAYS_BEFORE_EPOCH = YEAR_BEFORE_EPOCH * 365 + YEAR_BEFORE_EPOCH / 4
                                            - YEAR_BEFORE_EPOCH / 100 + YEAR_BEFORE_EPOCH / 400;
  localparam int unsigned DAYS_PER_400Y = 100 - 4 + 1 + 365 * 400;
  localparam int unsigned YEAR_SCALE = 400;
  // (DAYS_BEFORE_EPOCH + 6) mod 7, folded onto the day count since the epoch
  localparam int unsigned WEEKDAY_OFFSET = (DAYS_BEFORE_EPOCH + 6) % DAYS_PER_WEEK;

  // Floor reciprocals: estimate is exact or one low, fixed by one compare
  localparam int unsigned DAY_PRESHIFT = 7;
  localparam int unsigned DAY_SHIFT    = 25;
  localparam int unsigned DAY_RECIP    = (1 << DAY_SHIFT) / (SEC_PER_DAY >> DAY_PRESHIFT);
  localparam int unsigned WEEK_SHIFT   = 17;
  localparam int unsigned WEEK_RECIP   = (1 << WEEK_SHIFT) / DAYS_PER_WEEK;
  localparam int unsigned HOUR_SHIFT   = 17;
  localparam int unsigned HOUR_RECIP   = (1 << HOUR_SHIFT) / SEC_PER_HOUR;
  localparam int unsigned MIN_SHIFT    = 12;
  localparam int unsigned MIN_RECIP    = (1 << MIN_SHIFT) / SEC_PER_MIN;
  localparam int unsigned YEAR_SHIFT   = 29;
  localparam int unsigned YEAR_RECIP   = (1 << YEAR_SHIFT) / DAYS_PER_400Y;

  // Ceiling reciprocals, exact over the narrow operand ranges used
  localparam int unsigned CENT_SHIFT   = 15;
  localparam int unsigned CENT_RECIP   = ((1 << CENT_SHIFT) + 24) / 25;
  localparam int unsigned MONTH_SHIFT  = 14;
  localparam int unsigned MONTH_RECIP  = ((1 << MONTH_SHIFT) + 30) / 31;

  localparam logic [DOY_W-1:0] MONTH_START_PLAIN [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };
  localparam logic [DOY_W-1:0] MONTH_START_LEAP [13] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
  };

  typedef struct packed {
    logic [DAYNUM_W-1:0] day_num;
    logic [SOD_W-1:0]    sod;
  } split_t;

  typedef struct packed {
    logic [HOUR_W-1:0]    hour;
    logic [MINUTE_W-1:0]  minute;
    logic [SECOND_W-1:0]  second;
    logic [WEEKDAY_W-1:0] weekday;
  } clock_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                   input logic [MONTH_W-1:0] idx);
    logic [DOY_W-1:0] val;
    if (leap) begin
      val = MONTH_START_LEAP[idx];
    end else begin
      val = MONTH_START_PLAIN[idx];
    end
    return val;
  endfunction

  // cent is year / 100
  function automatic logic is_leap(input logic [YEAR_W-1:0] year,
                                   input logic [CENT_W-1:0] cent);
    logic [YEAR_W-1:0] whole;
    whole = YEAR_W'(cent) * YEAR_W'(100);
    return (year[1:0] == 2'd0) && ((whole != year) || (cent[1:0] == 2'd0));
  endfunction

endpackage

`default_nettype wire

// ===== design/ecd_in_if.sv =====
// Input channel of the converter: valid, ready and one epoch timestamp.
// Depends on ecd_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface ecd_in_if;
  logic                           valid;
  logic                           ready;
  logic [ecd_pkg::EPOCH_W-1:0]    epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

// ===== design/ecd_out_if.sv =====
// Result channel of the converter: valid, ready and the calendar fields.
// Depends on ecd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ecd_out_if;
  logic                            valid;
  logic                            ready;
  logic [ecd_pkg::YEAR_W-1:0]      year_out;
  logic [ecd_pkg::MONTH_W-1:0]     month_out;
  logic [ecd_pkg::DAY_W-1:0]       day_out;
  logic [ecd_pkg::HOUR_W-1:0]      hour_out;
  logic [ecd_pkg::MINUTE_W-1:0]    minute_out;
  logic [ecd_pkg::SECOND_W-1:0]    second_out;
  logic [ecd_pkg::WEEKDAY_W-1:0]   weekday_out;

  modport source (output valid, output year_out, output month_out, output day_out,
                  output hour_out, output minute_out, output second_out,
                  output weekday_out, input ready);
  modport sink   (input valid, input year_out, input month_out, input day_out,
                  input hour_out, input minute_out, input second_out,
                  input weekday_out, output ready);
endinterface

`default_nettype wire

// ===== design/ecd_day_split.sv =====
// Stages 1 to 3: split the timestamp into whole days and second of day.
// Depends on ecd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecd_day_split (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [ecd_pkg::EPOCH_W-1:0]  epoch_seconds,
  output ecd_pkg::split_t              split
);

  localparam int unsigned PW = ecd_pkg::EPOCH_W - ecd_pkg::DAY_PRESHIFT + ecd_pkg::DAYNUM_W;
  localparam int unsigned BW = ecd_pkg::EPOCH_W + 1;
  localparam int unsigned RW = ecd_pkg::SOD_W + 1;

  logic [ecd_pkg::EPOCH_W-1:0]  t1_r;
  logic [ecd_pkg::EPOCH_W-1:0]  t2_r;
  logic [ecd_pkg::DAYNUM_W-1:0] qe_r;
  logic [ecd_pkg::DAYNUM_W-1:0] qe_nxt;
  ecd_pkg::split_t              split_r;
  ecd_pkg::split_t              split_nxt;
  logic [PW-1:0]                prod;
  logic [BW-1:0]                back;
  logic [BW-1:0]                diff;
  logic [RW-1:0]                rem;

  always_comb begin
    prod   = PW'(t1_r[ecd_pkg::EPOCH_W-1:ecd_pkg::DAY_PRESHIFT]) * PW'(ecd_pkg::DAY_RECIP);
    qe_nxt = prod[PW-1:ecd_pkg::DAY_SHIFT];
  end

  always_comb begin
    back = BW'(qe_r) * BW'(ecd_pkg::SEC_PER_DAY);
    diff = BW'(t2_r) - back;
    rem  = diff[RW-1:0];
    if (rem >= RW'(ecd_pkg::SEC_PER_DAY)) begin
      split_nxt.day_num = qe_r + ecd_pkg::DAYNUM_W'(1);
      split_nxt.sod     = ecd_pkg::SOD_W'(rem - RW'(ecd_pkg::SEC_PER_DAY));
    end else begin
      split_nxt.day_num = qe_r;
      split_nxt.sod     = rem[ecd_pkg::SOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r    <= epoch_seconds;
      t2_r    <= t1_r;
      qe_r    <= qe_nxt;
      split_r <= split_nxt;
    end
  end

  assign split = split_r;

endmodule

`default_nettype wire

// ===== design/ecd_clock_fields.sv =====
// Stages 4 to 11 of the time-of-day side: hour, minute, second and weekday,
// then a delay line to line up with the date side. Depends on ecd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecd_clock_fields (
  input  logic             clk,
  input  logic             adv,
  input  ecd_pkg::split_t  split,
  output ecd_pkg::clock_t  clock
);

  localparam int unsigned XW  = ecd_pkg::DAYNUM_W + 1;
  localparam int unsigned WPW = 2 * XW;
  localparam int unsigned WQW = 13;
  localparam int unsigned HPW = 2 * ecd_pkg::SOD_W;
  localparam int unsigned HRW = 13;
  localparam int unsigned SHW = 12;
  localparam int unsigned MPW = 18;
  localparam int unsigned MRW = 7;
  localparam int unsigned DLY = ecd_pkg::STAGES - 7;

  // stage 4
  logic [XW-1:0]                x4_r;
  logic [WQW-1:0]               we4_r;
  logic [ecd_pkg::SOD_W-1:0]    sod4_r;
  logic [ecd_pkg::HOUR_W-1:0]   he4_r;
  // stage 5
  logic [ecd_pkg::WEEKDAY_W-1:0] wd5_r;
  logic [ecd_pkg::HOUR_W-1:0]    hr5_r;
  logic [SHW-1:0]                rh5_r;
  // stage 6
  logic [ecd_pkg::WEEKDAY_W-1:0] wd6_r;
  logic [ecd_pkg::HOUR_W-1:0]    hr6_r;
  logic [SHW-1:0]                rh6_r;
  logic [ecd_pkg::MINUTE_W-1:0]  me6_r;
  // stage 7 and delay line
  ecd_pkg::clock_t               c7_r;
  ecd_pkg::clock_t               dly_r [DLY];

  logic [XW-1:0]                 x4_nxt;
  logic [WPW-1:0]                wprod;
  logic [HPW-1:0]                hprod;
  logic [XW-1:0]                 wdiff;
  logic [3:0]                    wrem;
  logic [ecd_pkg::WEEKDAY_W-1:0] wd5_nxt;
  logic [HRW-1:0]                hrem;
  logic [ecd_pkg::HOUR_W-1:0]    hr5_nxt;
  logic [SHW-1:0]                rh5_nxt;
  logic [MPW-1:0]                mprod;
  logic [SHW-1:0]                mdiff;
  logic [MRW-1:0]                mrem;
  ecd_pkg::clock_t               c7_nxt;

  always_comb begin
    x4_nxt = XW'(split.day_num) + XW'(ecd_pkg::WEEKDAY_OFFSET);
    wprod  = WPW'(x4_nxt) * WPW'(ecd_pkg::WEEK_RECIP);
    hprod  = HPW'(split.sod) * HPW'(ecd_pkg::HOUR_RECIP);
  end

  always_comb begin
    wdiff = x4_r - XW'(we4_r) * XW'(ecd_pkg::DAYS_PER_WEEK);
    wrem  = wdiff[3:0];
    if (wrem >= 4'(ecd_pkg::DAYS_PER_WEEK)) begin
      wd5_nxt = ecd_pkg::WEEKDAY_W'(wrem - 4'(ecd_pkg::DAYS_PER_WEEK));
    end else begin
      wd5_nxt = wrem[ecd_pkg::WEEKDAY_W-1:0];
    end
    hrem = HRW'(sod4_r - ecd_pkg::SOD_W'(he4_r) * ecd_pkg::SOD_W'(ecd_pkg::SEC_PER_HOUR));
    if (hrem >= HRW'(ecd_pkg::SEC_PER_HOUR)) begin
      hr5_nxt = he4_r + ecd_pkg::HOUR_W'(1);
      rh5_nxt = SHW'(hrem - HRW'(ecd_pkg::SEC_PER_HOUR));
    end else begin
      hr5_nxt = he4_r;
      rh5_nxt = hrem[SHW-1:0];
    end
  end

  always_comb begin
    mprod = MPW'(rh5_r) * MPW'(ecd_pkg::MIN_RECIP);
  end

  always_comb begin
    mdiff = rh6_r - SHW'(me6_r) * SHW'(ecd_pkg::SEC_PER_MIN);
    mrem  = mdiff[MRW-1:0];
    c7_nxt.hour    = hr6_r;
    c7_nxt.weekday = wd6_r;
    if (mrem >= MRW'(ecd_pkg::SEC_PER_MIN)) begin
      c7_nxt.minute = me6_r + ecd_pkg::MINUTE_W'(1);
      c7_nxt.second = ecd_pkg::SECOND_W'(mrem - MRW'(ecd_pkg::SEC_PER_MIN));
    end else begin
      c7_nxt.minute = me6_r;
      c7_nxt.second = mrem[ecd_pkg::SECOND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x4_r   <= x4_nxt;
      we4_r  <= wprod[ecd_pkg::WEEK_SHIFT+WQW-1:ecd_pkg::WEEK_SHIFT];
      sod4_r <= split.sod;
      he4_r  <= hprod[ecd_pkg::HOUR_SHIFT+ecd_pkg::HOUR_W-1:ecd_pkg::HOUR_SHIFT];
      wd5_r  <= wd5_nxt;
      hr5_r  <= hr5_nxt;
      rh5_r  <= rh5_nxt;
      wd6_r  <= wd5_r;
      hr6_r  <= hr5_r;
      rh6_r  <= rh5_r;
      me6_r  <= mprod[ecd_pkg::MIN_SHIFT+ecd_pkg::MINUTE_W-1:ecd_pkg::MIN_SHIFT];
      c7_r   <= c7_nxt;
      dly_r[0] <= c7_r;
      for (int i = 1; i < DLY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign clock = dly_r[DLY-1];

endmodule

`default_nettype wire

// ===== design/ecd_date_fields.sv =====
// Stages 4 to 11 of the date side: year by 400-year estimate, one correction and a
// year-length compare, then month by day/31 and the month-start table. Depends on ecd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecd_date_fields (
  input  logic             clk,
  input  logic             adv,
  input  ecd_pkg::split_t  split,
  output ecd_pkg::date_t   date
);

  localparam int unsigned YW  = ecd_pkg::YEAR_W;
  localparam int unsigned AW  = ecd_pkg::ABSDAY_W;
  localparam int unsigned NW  = 29;
  localparam int unsigned YPW = NW + YW;
  localparam int unsigned YBW = NW + 2;
  localparam int unsigned YRW = 19;
  localparam int unsigned QW  = YW - 2;
  localparam int unsigned CPW = 21;
  localparam int unsigned R0W = 10;
  localparam int unsigned DW  = ecd_pkg::DOY_W;
  localparam int unsigned OPW = 18;
  localparam int unsigned MW  = ecd_pkg::MONTH_W;
  localparam int unsigned CW  = ecd_pkg::CENT_W;

  // stages 4 to 7
  logic [AW-1:0] days4_r, days5_r, days6_r, days7_r;
  logic [NW-1:0] n4_r, n5_r;
  logic [YW-1:0] ye5_r;
  logic [YW-1:0] y6_r, y7_r;
  logic [CW-1:0] cent7_r [3];
  // stage 8
  logic [YW-1:0]  y8_r;
  logic [R0W-1:0] rem8_r;
  logic           lp1_8_r, lp2_8_r;
  // stage 9
  logic [YW-1:0]  yr9_r;
  logic [DW-1:0]  rem9_r;
  logic           lp9_r;
  // stage 10
  logic [YW-1:0]  yr10_r;
  logic [DW-1:0]  rem10_r;
  logic           lp10_r;
  logic [MW-1:0]  mon10_r;
  // stage 11
  ecd_pkg::date_t date_r;

  logic [AW-1:0]  days4_nxt;
  logic [YPW-1:0] yprod;
  logic [YBW-1:0] ydiff;
  logic [YRW-1:0] yrem;
  logic [YW-1:0]  y6_nxt;
  logic [YW-1:0]  ycand [3];
  logic [CPW-1:0] cprod [3];
  logic [CW-1:0]  cent7_nxt [3];
  logic [AW-1:0]  base;
  logic [AW-1:0]  rdiff;
  logic [R0W-1:0] ylen;
  logic [YW-1:0]  yr9_nxt;
  logic [DW-1:0]  rem9_nxt;
  logic           lp9_nxt;
  logic [OPW-1:0] oprod;
  logic [MW-1:0]  mon_est;
  logic [MW-1:0]  mon10_nxt;
  logic [DW-1:0]  next_start;
  logic [MW-1:0]  mon;
  ecd_pkg::date_t date_nxt;

  function automatic logic [YW-1:0] ycand_hold(input logic [YW-1:0] y, input int unsigned k);
    return y + YW'(k);
  endfunction

  always_comb begin
    days4_nxt = AW'(split.day_num) + AW'(ecd_pkg::DAYS_BEFORE_EPOCH);
  end

  always_comb begin
    yprod = YPW'(n4_r) * YPW'(ecd_pkg::YEAR_RECIP);
  end

  always_comb begin
    ydiff = YBW'(n5_r) - YBW'(ye5_r) * YBW'(ecd_pkg::DAYS_PER_400Y);
    yrem  = ydiff[YRW-1:0];
    if (yrem >= YRW'(ecd_pkg::DAYS_PER_400Y)) begin
      y6_nxt = ye5_r + YW'(1);
    end else begin
      y6_nxt = ye5_r;
    end
  end

  // centuries of the year estimate and of the two years after it
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ycand[k]     = y6_r + YW'(k);
      cprod[k]     = CPW'(ycand[k][YW-1:2]) * CPW'(ecd_pkg::CENT_RECIP);
      cent7_nxt[k] = cprod[k][ecd_pkg::CENT_SHIFT+CW-1:ecd_pkg::CENT_SHIFT];
    end
  end

  always_comb begin
    base  = AW'(y7_r) * AW'(ecd_pkg::DAYS_PER_YEAR) + AW'(y7_r[YW-1:2])
          - AW'(cent7_r[0]) + AW'(cent7_r[0][CW-1:2]);
    rdiff = days7_r - base;
  end

  always_comb begin
    ylen = R0W'(ecd_pkg::DAYS_PER_YEAR) + R0W'(lp1_8_r);
    if (rem8_r >= ylen) begin
      rem9_nxt = DW'(rem8_r - ylen);
      yr9_nxt  = y8_r + YW'(2);
      lp9_nxt  = lp2_8_r;
    end else begin
      rem9_nxt = rem8_r[DW-1:0];
      yr9_nxt  = y8_r + YW'(1);
      lp9_nxt  = lp1_8_r;
    end
  end

  always_comb begin
    oprod   = OPW'(rem9_r) * OPW'(ecd_pkg::MONTH_RECIP);
    mon_est = oprod[ecd_pkg::MONTH_SHIFT+MW-1:ecd_pkg::MONTH_SHIFT] + MW'(1);
    if (mon_est > MW'(12)) begin
      mon10_nxt = MW'(12);
    end else begin
      mon10_nxt = mon_est;
    end
  end

  always_comb begin
    next_start = ecd_pkg::month_start(lp10_r, mon10_r);
    if ((mon10_r < MW'(12)) && (next_start <= rem10_r)) begin
      mon = mon10_r + MW'(1);
    end else begin
      mon = mon10_r;
    end
    date_nxt.year  = yr10_r;
    date_nxt.month = mon;
    date_nxt.day   = ecd_pkg::DAY_W'(rem10_r - ecd_pkg::month_start(lp10_r, mon - MW'(1))
                                     + DW'(1));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      days4_r <= days4_nxt;
      n4_r    <= NW'(days4_nxt) * NW'(ecd_pkg::YEAR_SCALE);
      days5_r <= days4_r;
      n5_r    <= n4_r;
      ye5_r   <= yprod[ecd_pkg::YEAR_SHIFT+YW-1:ecd_pkg::YEAR_SHIFT];
      days6_r <= days5_r;
      y6_r    <= y6_nxt;
      days7_r <= days6_r;
      y7_r    <= y6_r;
      for (int k = 0; k < 3; k++) begin
        cent7_r[k] <= cent7_nxt[k];
      end
      y8_r    <= y7_r;
      rem8_r  <= rdiff[R0W-1:0];
      lp1_8_r <= ecd_pkg::is_leap(ycand_hold(y7_r, 1), cent7_r[1]);
      lp2_8_r <= ecd_pkg::is_leap(ycand_hold(y7_r, 2), cent7_r[2]);
      yr9_r   <= yr9_nxt;
      rem9_r  <= rem9_nxt;
      lp9_r   <= lp9_nxt;
      yr10_r  <= yr9_r;
      rem10_r <= rem9_r;
      lp10_r  <= lp9_r;
      mon10_r <= mon10_nxt;
      date_r  <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

`default_nettype wire

// ===== design/epoch_seconds_to_calendar_date.sv =====
// Epoch seconds to calendar date converter, top level.
// Takes 32-bit seconds since 1970-01-01 00:00:00 on in_ch and returns year,
// month, day, hour, minute, second and weekday code on out_ch. The weekday
// code is (days since 0001-01-01 + 6) mod 7, so Monday is 6 and Tuesday 0.
// Both channels use valid/ready; a transaction completes when both are high.
// Throughput: one transaction per cycle, sustained, while out_ch.ready is high.
// Depth: eleven register stages from input to result. The depth comes from the
// chain of reciprocal multiplies (days, hours, minutes, year) and the year and
// month corrections.
// Stall: when a valid result waits and out_ch.ready is low, the whole pipeline
// holds and in_ch.ready drops in the same cycle; nothing is lost or repeated.
// Reset (rst_n low at a clock edge) clears all stage valid bits; no stored
// state beyond the pipeline exists.
// Depends on ecd_pkg, ecd_in_if, ecd_out_if, ecd_day_split, ecd_clock_fields
// and ecd_date_fields.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar_date (
  input  logic         clk,
  input  logic         rst_n,
  ecd_in_if.sink       in_ch,
  ecd_out_if.source    out_ch
);

  logic [ecd_pkg::STAGES-1:0] vld_r;
  logic [ecd_pkg::STAGES-1:0] vld_nxt;
  logic                       adv;
  ecd_pkg::split_t            split;
  ecd_pkg::clock_t            clock;
  ecd_pkg::date_t             date;

  assign adv     = !vld_r[ecd_pkg::STAGES-1] || out_ch.ready;
  assign vld_nxt = {vld_r[ecd_pkg::STAGES-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  ecd_day_split u_day_split (
    .clk           (clk),
    .adv           (adv),
    .epoch_seconds (in_ch.epoch_seconds),
    .split         (split)
  );

  ecd_clock_fields u_clock_fields (
    .clk   (clk),
    .adv   (adv),
    .split (split),
    .clock (clock)
  );

  ecd_date_fields u_date_fields (
    .clk   (clk),
    .adv   (adv),
    .split (split),
    .date  (date)
  );

  assign in_ch.ready        = adv && rst_n;
  assign out_ch.valid       = vld_r[ecd_pkg::STAGES-1];
  assign out_ch.year_out    = date.year;
  assign out_ch.month_out   = date.month;
  assign out_ch.day_out     = date.day;
  assign out_ch.hour_out    = clock.hour;
  assign out_ch.minute_out  = clock.minute;
  assign out_ch.second_out  = clock.second;
  assign out_ch.weekday_out = clock.weekday;

endmodule

`default_nettype wire
